// ===== src/lcdseq_pkg.sv =====
package lcdseq_pkg;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_FREQ = 2'd1;
  localparam logic [1:0] MODE_RES  = 2'd2;

  localparam int unsigned VALUE_W = 20;
  localparam int unsigned REM_W   = 14;
  localparam logic [REM_W-1:0] VALUE_MAX = 14'd9999;

  localparam logic [7:0] ADDR_LINE0 = 8'h80;
  localparam logic [7:0] ADDR_LINE1 = 8'hC0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [3:0] WAIT_BASE  = 4'd2;
  localparam logic [3:0] WAIT_RESET = 4'd12;

  // Reset nibbles are 0x3, 0x3, 0x3, 0x2.
  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;
  localparam int unsigned WAKE_NIBS = 4;

  localparam logic [4:0] LAST_NIB_INIT = 5'd11;
  localparam logic [4:0] LAST_NIB_DISP = 5'd17;

  localparam logic [3:0][7:0] INIT_CMDS = {8'h01, 8'h06, 8'h0C, 8'h28};

  // One display command as handed from the front to the back.
  typedef struct packed {
    logic [1:0]      mode;
    logic [3:0][7:0] digits;  // digits[0] is the thousands character
  } cmd_t;

  // Fixed characters of the text line; pos 0..1 prefix, 6..7 suffix.
  function automatic logic [7:0] fixed_char(input logic [1:0] mode, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CHAR_SPACE;
    case (pos)
      3'd0:    ch = (mode == MODE_FREQ) ? 8'h46 : 8'h52;
      3'd1:    ch = 8'h3A;
      3'd6:    ch = (mode == MODE_FREQ) ? 8'h48 : 8'h4F;
      3'd7:    ch = (mode == MODE_FREQ) ? 8'h7A : 8'h68;
      default: ch = CHAR_SPACE;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/lcdseq_if.sv =====
interface lcdseq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [19:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface lcdseq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_word;
  logic [3:0] wait_ms;
  logic       last;

  modport source (output valid, output shift_word, output wait_ms, output last, input ready);
  modport sink   (input valid, input shift_word, input wait_ms, input last, output ready);
endinterface

// ===== src/lcdseq_front.sv =====
module lcdseq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic [lcdseq_pkg::VALUE_W-1:0] in_value,
  output logic                         push,
  output lcdseq_pkg::cmd_t             push_data,
  input  logic                         full
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

  fstate_t                         state_r;
  logic [1:0]                      cnt_r;
  logic [lcdseq_pkg::REM_W-1:0]    rem_r;
  logic                            seen_r;
  lcdseq_pkg::cmd_t                cmd_r;

  logic [lcdseq_pkg::REM_W-1:0]    div_c;
  logic [3:0]                      digit_c;
  logic                            seen_c;
  logic [lcdseq_pkg::REM_W-1:0]    sat_c;
  logic                            accept;

  always_comb begin
    case (cnt_r)
      2'd0:    div_c = 14'd1000;
      2'd1:    div_c = 14'd100;
      2'd2:    div_c = 14'd10;
      default: div_c = 14'd1;
    endcase
    // Largest k with k*div <= remainder; the compares are independent.
    digit_c = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (18'(rem_r) >= 18'(k) * 18'(div_c)) begin
        digit_c = 4'(k);
      end
    end
    seen_c = seen_r || (digit_c != 4'd0) || (cnt_r == 2'd3);
    sat_c  = (in_value > 20'(lcdseq_pkg::VALUE_MAX)) ? lcdseq_pkg::VALUE_MAX
                                                     : in_value[lcdseq_pkg::REM_W-1:0];
  end

  assign push      = (state_r == F_PUSH) && !full;
  assign push_data = cmd_r;
  assign in_ready  = (state_r == F_IDLE) || push;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= 2'd0;
      seen_r  <= 1'b0;
    end else begin
      case (state_r)
        F_CONV: begin
          rem_r                <= rem_r - 14'(18'(digit_c) * 18'(div_c));
          seen_r               <= seen_c;
          cmd_r.digits[cnt_r]  <= seen_c ? (lcdseq_pkg::CHAR_ZERO + 8'(digit_c))
                                         : lcdseq_pkg::CHAR_SPACE;
          cnt_r                <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          // A beat taken in the same cycle sets the next state below.
          if (push && !accept) begin
            state_r <= F_IDLE;
          end
        end
        default: ;
      endcase
      // Unused mode 3 is taken and dropped.
      if (accept) begin
        if (in_mode == lcdseq_pkg::MODE_INIT || in_mode == lcdseq_pkg::MODE_FREQ ||
            in_mode == lcdseq_pkg::MODE_RES) begin
          state_r    <= F_CONV;
          cmd_r.mode <= in_mode;
          rem_r      <= sat_c;
          cnt_r      <= 2'd0;
          seen_r     <= 1'b0;
        end else begin
          state_r <= F_IDLE;
        end
      end
    end
  end

endmodule

// ===== src/lcdseq_fifo.sv =====
module lcdseq_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcdseq_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output lcdseq_pkg::cmd_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  lcdseq_pkg::cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/lcdseq_back.sv =====
module lcdseq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  lcdseq_pkg::cmd_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_shift_word,
  output logic [3:0]       out_wait_ms,
  output logic             out_last
);

  logic             busy_r;
  lcdseq_pkg::cmd_t cmd_r;
  logic [4:0]       nib_r;
  logic [1:0]       ph_r;
  logic             out_valid_r;
  logic [7:0]       word_r;
  logic [3:0]       wait_r;
  logic             last_r;

  logic             fire;
  logic             is_init;
  logic [4:0]       k_c;
  logic [3:0]       bidx_c;
  logic [2:0]       tidx_c;
  logic [7:0]       byte_c;
  logic [3:0]       nibble_c;
  logic             rs_c;
  logic             tail_c;
  logic             last_c;

  assign fire    = busy_r && (!out_valid_r || out_ready);
  assign q_pop   = !busy_r && q_valid;
  assign is_init = (cmd_r.mode == lcdseq_pkg::MODE_INIT);
  assign tail_c  = (ph_r == 2'd2);

  always_comb begin
    k_c    = nib_r - 5'(lcdseq_pkg::WAKE_NIBS);
    bidx_c = nib_r[4:1];
    tidx_c = 3'(bidx_c - 4'd1);
    byte_c = 8'h00;
    rs_c   = 1'b0;
    if (is_init) begin
      byte_c = lcdseq_pkg::INIT_CMDS[k_c[2:1]];
    end else if (bidx_c == 4'd0) begin
      byte_c = (cmd_r.mode == lcdseq_pkg::MODE_FREQ) ? lcdseq_pkg::ADDR_LINE0
                                                     : lcdseq_pkg::ADDR_LINE1;
    end else begin
      rs_c = 1'b1;
      if (tidx_c >= 3'd2 && tidx_c <= 3'd5) begin
        byte_c = cmd_r.digits[2'(tidx_c - 3'd2)];
      end else begin
        byte_c = lcdseq_pkg::fixed_char(cmd_r.mode, tidx_c);
      end
    end
    // Each byte is sent high nibble first, counted from the start of its byte run.
    if (is_init) begin
      if (nib_r < 5'(lcdseq_pkg::WAKE_NIBS)) begin
        nibble_c = (nib_r == 5'd3) ? lcdseq_pkg::NIB_4BIT : lcdseq_pkg::NIB_WAKE;
      end else begin
        nibble_c = k_c[0] ? byte_c[3:0] : byte_c[7:4];
      end
    end else begin
      nibble_c = nib_r[0] ? byte_c[3:0] : byte_c[7:4];
    end
    last_c = tail_c && (nib_r == (is_init ? lcdseq_pkg::LAST_NIB_INIT
                                          : lcdseq_pkg::LAST_NIB_DISP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      nib_r       <= 5'd0;
      ph_r        <= 2'd0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        cmd_r  <= q_data;
        nib_r  <= 5'd0;
        ph_r   <= 2'd0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        word_r      <= {ph_r == 2'd1, rs_c, 2'b00, nibble_c};
        wait_r      <= (is_init && tail_c && nib_r < 5'd2) ? lcdseq_pkg::WAIT_RESET
                                                           : lcdseq_pkg::WAIT_BASE;
        last_r      <= last_c;
        if (tail_c) begin
          ph_r  <= 2'd0;
          nib_r <= nib_r + 5'd1;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
        if (last_c) begin
          busy_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_shift_word = word_r;
  assign out_wait_ms    = wait_r;
  assign out_last       = last_r;

endmodule

// ===== src/char_lcd_nibble_sequencer.sv =====
// Character LCD nibble sequencer: each input beat is one command (mode 0
// initializes the display, mode 1 writes the frequency line "F:ddddHz" on
// line 0, mode 2 writes the resistance line "R:ddddOh" on line 1; mode 3
// is taken and dropped) and yields a run of output beats, one per shift
// register word, with last set on the final word. An init run is 36 beats,
// a display run is 54 beats, and the output side produces one beat per
// clock while it is not stalled, and pauses between runs while the
// next command is pulled from the queue. The front end takes a command
// apart into four decimal characters, one digit per cycle, and then hands
// it to the queue; this overlaps the back end's run, so sustained
// throughput is set by the word sequencer. Values above 9999 show as 9999,
// and leading zeros are shown as spaces.
module char_lcd_nibble_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic               clk,
  input logic               rst_n,
  lcdseq_in_if.sink         in_ch,
  lcdseq_out_if.source      out_ch
);

  // Command queue between the digit converter and the word sequencer.
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  lcdseq_pkg::cmd_t q_wr_data;
  lcdseq_pkg::cmd_t q_rd_data;

  // The front end saturates the value and converts it to characters.
  lcdseq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_value  (in_ch.value),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full)
  );

  lcdseq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rd_data)
  );

  // The back end walks nibbles and the three enable phases of each nibble,
  // and holds the current word in an output register.
  lcdseq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rd_data),
    .q_pop          (q_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_shift_word (out_ch.shift_word),
    .out_wait_ms    (out_ch.wait_ms),
    .out_last       (out_ch.last)
  );

endmodule

// ===== src/lcdseq_checker.sv =====
module lcdseq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_shift_word,
  input logic [3:0] out_wait_ms,
  input logic       out_last
);

  // A stalled beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat withdrawn while stalled");

  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shift_word[5:4] == 2'b00)
    else $error("unused shift word bits set");

  a_wait_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wait_ms == 4'd2 || out_wait_ms == 4'd12))
    else $error("hold time out of range");

  // The long hold only follows an enable-low command nibble.
  a_long_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_ms == 4'd12 |-> out_shift_word[7:6] == 2'b00 && !out_last)
    else $error("long hold on an unexpected word");

  // A run never ends with enable high.
  a_enable_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shift_word[7] |-> !out_last)
    else $error("run ends with enable high");

endmodule

bind char_lcd_nibble_sequencer lcdseq_checker u_lcdseq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_shift_word (out_ch.shift_word),
  .out_wait_ms    (out_ch.wait_ms),
  .out_last       (out_ch.last)
);
